/* rtl/unsorted_value_table_defines.svh */
// ---------------------------------------------------------------------------
// unsorted_value_table_defines
// Assertion macros used by the unsorted value table RTL.
// ---------------------------------------------------------------------------
`ifndef UNSORTED_VALUE_TABLE_DEFINES_SVH
`define UNSORTED_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define UVT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("unsorted_value_table check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define UVT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("unsorted_value_table check failed");
`else
`define UVT_ASSERT_IMPL(name, ante, cons)
`define UVT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/uvt_pkg.sv */
// ---------------------------------------------------------------------------
// uvt_pkg
// Types, sizes and codes of the unsorted value table.
// ---------------------------------------------------------------------------
package uvt_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 7;
  localparam int OP_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT      = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_ONE = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_ALL = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [FILL_W-1:0] match_count;
    logic [FILL_W-1:0] length_after;
    logic              is_empty_flag;
    logic              is_full_flag;
    logic              status;
  } out_t;

endpackage

/* rtl/uvt_ram.sv */
// ---------------------------------------------------------------------------
// uvt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module uvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/unsorted_value_table.sv */
// ---------------------------------------------------------------------------
// unsorted_value_table
// Unordered store of signed 32-bit values with append, search, count,
// remove first, remove all and clear.
// ---------------------------------------------------------------------------
// The block takes one request at a time and holds in_ready low until that
// request's result beat has been placed in the output register; a stalled
// result beat keeps the block in its final state. Append, clear and unknown
// codes go from idle straight to the final state. Search, count and the
// removals walk the stored entries through one compare unit on a single RAM
// read port with registered data: each entry examined passes a read state
// and a compare state, each entry removed adds a move state, and a walk that
// runs to the end of the store ends with a last bound check in the read
// state. Removal copies the last entry into the freed slot. Capacity_limit
// is written over the APB port at byte address 0; values above 64 act as 64.
module unsorted_value_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvt_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output uvt_pkg::out_t      out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "unsorted_value_table_defines.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_MV   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [uvt_pkg::FILL_W-1:0] DEPTH_F = uvt_pkg::FILL_W'(uvt_pkg::DEPTH);

  logic [2:0]                    state_r, state_nxt;
  logic [uvt_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [uvt_pkg::FILL_W-1:0]    idx_r, idx_nxt;
  logic [uvt_pkg::FILL_W-1:0]    cnt_r, cnt_nxt;
  logic                          found_r, found_nxt;
  logic                          status_r, status_nxt;
  logic [uvt_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [uvt_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [uvt_pkg::CAP_W-1:0]     cap_r, cap_nxt;
  logic                          out_valid_r, out_valid_nxt;
  uvt_pkg::out_t                 out_r, out_nxt;

  logic [uvt_pkg::FILL_W-1:0]    eff_cap;
  logic [uvt_pkg::FILL_W-1:0]    fill_dec;
  logic                          in_fire;
  logic                          out_load;
  logic                          hit;
  logic                          cfg_wr;

  logic                          ram_we;
  logic [uvt_pkg::ADDR_W-1:0]    ram_waddr;
  logic [uvt_pkg::VALUE_W-1:0]   ram_wdata;
  logic [uvt_pkg::ADDR_W-1:0]    ram_raddr;
  logic [uvt_pkg::VALUE_W-1:0]   ram_rdata;

  uvt_ram #(
    .WIDTH (uvt_pkg::VALUE_W),
    .DEPTH (uvt_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_cap  = (uvt_pkg::FILL_W'(cap_r) > DEPTH_F) ? DEPTH_F : uvt_pkg::FILL_W'(cap_r);
  assign fill_dec = fill_r - uvt_pkg::FILL_W'(1);
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign hit      = (ram_rdata == val_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // APB: one register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == uvt_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == uvt_pkg::REG_CAPACITY) ? {25'd0, cap_r} : 32'd0;
  assign cap_nxt = cfg_wr ? pwdata[uvt_pkg::CAP_W-1:0] : cap_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    ram_we     = 1'b0;
    ram_waddr  = fill_r[uvt_pkg::ADDR_W-1:0];
    ram_wdata  = in_data.value;
    ram_raddr  = idx_r[uvt_pkg::ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_data.op;
          val_nxt    = in_data.value;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          state_nxt  = ST_FIN;
          case (in_data.op)
            uvt_pkg::OP_APPEND: begin
              if (fill_r >= eff_cap) begin
                status_nxt = 1'b1;
              end else begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + uvt_pkg::FILL_W'(1);
              end
            end
            uvt_pkg::OP_SEARCH, uvt_pkg::OP_COUNT,
            uvt_pkg::OP_REMOVE_ONE, uvt_pkg::OP_REMOVE_ALL: begin
              state_nxt = ST_RD;
            end
            uvt_pkg::OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        if (idx_r >= fill_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        idx_nxt   = idx_r + uvt_pkg::FILL_W'(1);
        state_nxt = ST_RD;
        case (op_r)
          uvt_pkg::OP_SEARCH: begin
            if (hit) begin
              found_nxt = 1'b1;
              state_nxt = ST_FIN;
            end
          end
          uvt_pkg::OP_COUNT: begin
            if (hit) begin
              cnt_nxt = cnt_r + uvt_pkg::FILL_W'(1);
            end
          end
          default: begin
            // Both removals: on a hit, fetch the last entry to fill the hole.
            if (hit) begin
              idx_nxt   = idx_r;
              fill_nxt  = fill_dec;
              ram_raddr = fill_dec[uvt_pkg::ADDR_W-1:0];
              state_nxt = ST_MV;
              if (op_r == uvt_pkg::OP_REMOVE_ONE) begin
                found_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + uvt_pkg::FILL_W'(1);
              end
            end
          end
        endcase
      end
      ST_MV: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[uvt_pkg::ADDR_W-1:0];
        ram_wdata = ram_rdata;
        // Remove all re-examines the entry that was just moved in.
        state_nxt = (op_r == uvt_pkg::OP_REMOVE_ONE) ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt               = out_r;
    out_valid_nxt         = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_nxt.found             = found_r;
      out_nxt.match_count       = cnt_r;
      out_nxt.length_after      = fill_r;
      out_nxt.is_empty_flag     = (fill_r == '0);
      out_nxt.is_full_flag      = (fill_r >= eff_cap);
      out_nxt.status            = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cap_r       <= uvt_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    out_r    <= out_nxt;
  end

  `UVT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= DEPTH_F)
  `UVT_ASSERT_IMPL(a_cmp_in_range, state_r == ST_CMP, idx_r < fill_r)
  `UVT_ASSERT_NEXT(a_append_grows,
    in_fire && (in_data.op == uvt_pkg::OP_APPEND) && (fill_r < eff_cap),
    fill_r == $past(fill_r) + uvt_pkg::FILL_W'(1))
  `UVT_ASSERT_IMPL(a_overflow_full, out_load && status_r, fill_r >= eff_cap)
  `UVT_ASSERT_NEXT(a_result_waits, (state_r == ST_FIN) && out_valid_r && !out_ready,
    state_r == ST_FIN)

endmodule
